/* rtl/rolling_gain_loss_ratio_core_assert.svh */
// Assertion macros used by the port-level checker of the gain/loss ratio core.
`ifndef ROLLING_GAIN_LOSS_RATIO_CORE_ASSERT_SVH
`define ROLLING_GAIN_LOSS_RATIO_CORE_ASSERT_SVH

// Consequent checked in the cycle after the antecedent, disabled during reset.
`define RGLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent, disabled during reset.
`define RGLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// State seen on the cycle after a reset edge.
`define RGLR_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rglr_pkg.sv */
// Types, constants and register codes of the gain/loss ratio core.
`default_nettype none

package rglr_pkg;

    localparam int MAX_WINDOW_DEF    = 64;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 32;
    localparam int RATIO_W    = 32;
    localparam int DELTA_W    = 33;
    localparam int MAG_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int WIN_REG_W  = 7;

    localparam int MIN_WINDOW = 4;
    localparam int MIN_NEED   = 2;

    localparam logic [WIN_REG_W-1:0] WINDOW_LENGTH_RST   = 7'd20;
    localparam logic [WIN_REG_W-1:0] MIN_SAMPLES_RST     = 7'd5;
    localparam logic [RATIO_W-1:0]   MAX_RATIO_RST       = 32'd6553600;
    localparam logic [RATIO_W-1:0]   HIGH_GAIN_LEVEL_RST = 32'd131072;
    localparam logic [RATIO_W-1:0]   HIGH_LOSS_LEVEL_RST = 32'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH   = 3'd0,
        REG_MIN_SAMPLES     = 3'd1,
        REG_MAX_RATIO       = 3'd2,
        REG_HIGH_GAIN_LEVEL = 3'd3,
        REG_HIGH_LOSS_LEVEL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [WIN_REG_W-1:0] window_length;
        logic [WIN_REG_W-1:0] fill_need;
        logic [RATIO_W-1:0]   ratio_ceiling;
        logic [RATIO_W-1:0]   high_gain_level;
        logic [RATIO_W-1:0]   high_loss_level;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic remove;
        logic add;
        logic decide;
        logic div_step;
        logic cap;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_status;

endpackage

`default_nettype wire

/* rtl/rglr_regs.sv */
// Configuration registers and the state clear that follows a write to a listed register.
`default_nettype none

module rglr_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [rglr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rglr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rglr_pkg::t_cfg                        o_cfg,
    output logic                                  o_clear
);

    rglr_pkg::t_cfg r_cfg;
    logic           r_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length   <= rglr_pkg::WINDOW_LENGTH_RST;
            r_cfg.fill_need       <= rglr_pkg::MIN_SAMPLES_RST;
            r_cfg.ratio_ceiling   <= rglr_pkg::MAX_RATIO_RST;
            r_cfg.high_gain_level <= rglr_pkg::HIGH_GAIN_LEVEL_RST;
            r_cfg.high_loss_level <= rglr_pkg::HIGH_LOSS_LEVEL_RST;
            r_clear               <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rglr_pkg::REG_WINDOW_LENGTH: begin
                        r_cfg.window_length <= i_cfg_data[rglr_pkg::WIN_REG_W-1:0];
                        r_clear             <= 1'b1;
                    end
                    rglr_pkg::REG_MIN_SAMPLES: begin
                        r_cfg.fill_need <= i_cfg_data[rglr_pkg::WIN_REG_W-1:0];
                        r_clear         <= 1'b1;
                    end
                    rglr_pkg::REG_MAX_RATIO: begin
                        r_cfg.ratio_ceiling <= i_cfg_data[rglr_pkg::RATIO_W-1:0];
                        r_clear             <= 1'b1;
                    end
                    rglr_pkg::REG_HIGH_GAIN_LEVEL: begin
                        r_cfg.high_gain_level <= i_cfg_data[rglr_pkg::RATIO_W-1:0];
                        r_clear               <= 1'b1;
                    end
                    rglr_pkg::REG_HIGH_LOSS_LEVEL: begin
                        r_cfg.high_loss_level <= i_cfg_data[rglr_pkg::RATIO_W-1:0];
                        r_clear               <= 1'b1;
                    end
                    default: begin
                        // unlisted index: drop the write
                    end
                endcase
            end
        end
    end

    assign o_cfg   = r_cfg;
    assign o_clear = r_clear;

endmodule

`default_nettype wire

/* rtl/rglr_ctrl.sv */
// Sequencer of the gain/loss ratio core: item intake, window update, divide, publish.
`default_nettype none

module rglr_ctrl #(
    parameter int DIV_W = rglr_pkg::FRACTION_BITS_DEF + 32 + $clog2(rglr_pkg::MAX_WINDOW_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  rglr_pkg::t_status  i_status,
    output rglr_pkg::t_cmd     o_cmd
);

    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_ADD,
        S_DECIDE,
        S_DIVIDE,
        S_CAP,
        S_PUBLISH
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.remove   = (r_state == S_REMOVE);
        o_cmd.add      = (r_state == S_ADD);
        o_cmd.decide   = (r_state == S_DECIDE);
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.cap      = (r_state == S_CAP);
        // publish only into a free or emptying output slot
        o_cmd.publish  = (r_state == S_PUBLISH) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_clear) begin
                r_state <= S_IDLE;
                r_step  <= '0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_state <= S_REMOVE;
                        end
                    end
                    S_REMOVE: r_state <= S_ADD;
                    S_ADD:    r_state <= S_DECIDE;
                    S_DECIDE: begin
                        if (i_status.need_div) begin
                            r_step  <= STEP_W'(DIV_W - 1);
                            r_state <= S_DIVIDE;
                        end else begin
                            r_state <= S_PUBLISH;
                        end
                    end
                    S_DIVIDE: begin
                        if (r_step == '0) begin
                            r_state <= S_CAP;
                        end else begin
                            r_step <= r_step - STEP_W'(1);
                        end
                    end
                    S_CAP: r_state <= S_PUBLISH;
                    S_PUBLISH: begin
                        if (!r_out_valid || i_out_ready) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/rglr_datapath.sv */
// Datapath: delta ring, running sums, restoring divider, thresholds and result register.
`default_nettype none

module rglr_datapath #(
    parameter int MAX_WINDOW    = rglr_pkg::MAX_WINDOW_DEF,
    parameter int FRACTION_BITS = rglr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_clear,
    input  rglr_pkg::t_cfg                              i_cfg,
    input  rglr_pkg::t_cmd                              i_cmd,
    output rglr_pkg::t_status                           o_status,
    input  wire logic signed [rglr_pkg::SAMPLE_W-1:0]   i_sample,
    output logic [rglr_pkg::RATIO_W-1:0]                o_ratio,
    output logic [32+$clog2(MAX_WINDOW)-1:0]            o_gain_total,
    output logic [32+$clog2(MAX_WINDOW)-1:0]            o_loss_total,
    output logic                                        o_gain_event,
    output logic                                        o_loss_event,
    output logic [rglr_pkg::COUNT_W-1:0]                o_gain_event_count,
    output logic [rglr_pkg::COUNT_W-1:0]                o_loss_event_count,
    output logic [rglr_pkg::COUNT_W-1:0]                o_sample_count
);

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int ACC_W   = 32 + $clog2(MAX_WINDOW);
    localparam int DW      = ACC_W + FRACTION_BITS;
    localparam int DELTA_W = rglr_pkg::DELTA_W;
    localparam int MAG_W   = rglr_pkg::MAG_W;
    localparam int RATIO_W = rglr_pkg::RATIO_W;
    localparam int COUNT_W = rglr_pkg::COUNT_W;
    localparam int WREG_W  = rglr_pkg::WIN_REG_W;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRACTION_BITS;

    function automatic logic [MAG_W-1:0] magnitude(input logic [DELTA_W-1:0] v);
        logic [DELTA_W-1:0] neg;
        neg = -v;
        return v[DELTA_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // ring storage
    logic [DELTA_W-1:0]  r_ring [MAX_WINDOW];
    logic [DELTA_W-1:0]  r_rd;
    logic [DELTA_W-1:0]  r_delta;

    // window state
    logic signed [rglr_pkg::SAMPLE_W-1:0] r_last;
    logic                r_has_last;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_fill;
    logic [ACC_W-1:0]    r_gain;
    logic [ACC_W-1:0]    r_loss;
    logic                r_was_gain;
    logic                r_was_loss;
    logic [COUNT_W-1:0]  r_gain_events;
    logic [COUNT_W-1:0]  r_loss_events;
    logic [COUNT_W-1:0]  r_seen;

    // divider and ratio
    logic [ACC_W-1:0]    r_rem;
    logic [DW-1:0]       r_dsr;
    logic [RATIO_W-1:0]  r_ratio;

    // result register
    logic [RATIO_W-1:0]  r_o_ratio;
    logic [ACC_W-1:0]    r_o_gain;
    logic [ACC_W-1:0]    r_o_loss;
    logic                r_o_gain_ev;
    logic                r_o_loss_ev;
    logic [COUNT_W-1:0]  r_o_gain_cnt;
    logic [COUNT_W-1:0]  r_o_loss_cnt;
    logic [COUNT_W-1:0]  r_o_seen;

    logic [DELTA_W-1:0]  n_delta;
    logic [CNT_W-1:0]    eff_window;
    logic [WREG_W-1:0]   need;
    logic                fill_ok;
    logic                old_valid;
    logic [DELTA_W-1:0]  leave_delta;
    logic [ACC_W:0]      trial;
    logic [ACC_W:0]      diff;
    logic                fits;
    logic                now_gain;
    logic                now_loss;
    logic                ev_gain;
    logic                ev_loss;

    always_comb begin
        if (i_cfg.window_length < WREG_W'(rglr_pkg::MIN_WINDOW)) begin
            eff_window = CNT_W'(rglr_pkg::MIN_WINDOW);
        end else if (32'(i_cfg.window_length) > 32'(MAX_WINDOW)) begin
            eff_window = CNT_W'(MAX_WINDOW);
        end else begin
            eff_window = CNT_W'(i_cfg.window_length);
        end
    end

    assign need    = (i_cfg.fill_need < WREG_W'(rglr_pkg::MIN_NEED)) ?
                     WREG_W'(rglr_pkg::MIN_NEED) : i_cfg.fill_need;
    assign fill_ok = 32'(r_fill) >= 32'(need);

    assign n_delta = r_has_last ?
                     ({i_sample[rglr_pkg::SAMPLE_W-1], i_sample} -
                      {r_last[rglr_pkg::SAMPLE_W-1], r_last}) : '0;

    // entries at or past the fill count have not been written since the clear
    assign old_valid   = (CNT_W'(r_head) < r_fill);
    assign leave_delta = old_valid ? r_rd : '0;

    assign trial = {r_rem, r_dsr[DW-1]};
    assign diff  = trial - {1'b0, r_loss};
    assign fits  = (trial >= {1'b0, r_loss});

    assign now_gain = (r_ratio >= i_cfg.high_gain_level);
    assign now_loss = (r_ratio <= i_cfg.high_loss_level);
    assign ev_gain  = now_gain && !r_was_gain;
    assign ev_loss  = now_loss && !r_was_loss;

    assign o_status.need_div = fill_ok && (r_loss != '0);

    // read-first ring port: fetch the leaving entry and store the new delta
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd           <= r_ring[r_head];
            r_ring[r_head] <= n_delta;
            r_delta        <= n_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_last        <= '0;
            r_has_last    <= 1'b0;
            r_head        <= '0;
            r_fill        <= '0;
            r_gain        <= '0;
            r_loss        <= '0;
            r_was_gain    <= 1'b0;
            r_was_loss    <= 1'b0;
            r_gain_events <= '0;
            r_loss_events <= '0;
            r_seen        <= '0;
        end else begin
            if (i_cmd.start) begin
                r_last     <= i_sample;
                r_has_last <= 1'b1;
                r_seen     <= r_seen + COUNT_W'(1);
            end
            if (i_cmd.remove) begin
                if (leave_delta[DELTA_W-1]) begin
                    r_loss <= r_loss - ACC_W'(magnitude(leave_delta));
                end else begin
                    r_gain <= r_gain - ACC_W'(magnitude(leave_delta));
                end
            end
            if (i_cmd.add) begin
                if (r_delta[DELTA_W-1]) begin
                    r_loss <= r_loss + ACC_W'(magnitude(r_delta));
                end else begin
                    r_gain <= r_gain + ACC_W'(magnitude(r_delta));
                end
                if (CNT_W'(r_head) + CNT_W'(1) >= eff_window) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + IDX_W'(1);
                end
                if (r_fill < eff_window) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.publish) begin
                r_was_gain <= now_gain;
                r_was_loss <= now_loss;
                if (ev_gain) begin
                    r_gain_events <= r_gain_events + COUNT_W'(1);
                end
                if (ev_loss) begin
                    r_loss_events <= r_loss_events + COUNT_W'(1);
                end
            end
        end
    end

    // divider: one quotient bit a cycle, quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_rem <= '0;
            r_dsr <= {r_gain, FRACTION_BITS'(0)};
            if (fill_ok && (r_gain != '0)) begin
                r_ratio <= i_cfg.ratio_ceiling;
            end else begin
                r_ratio <= RATIO_ONE;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            r_dsr <= {r_dsr[DW-2:0], fits};
        end
        if (i_cmd.cap) begin
            r_ratio <= (r_dsr > DW'(i_cfg.ratio_ceiling)) ?
                       i_cfg.ratio_ceiling : r_dsr[RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_ratio    <= r_ratio;
            r_o_gain     <= r_gain;
            r_o_loss     <= r_loss;
            r_o_gain_ev  <= ev_gain;
            r_o_loss_ev  <= ev_loss;
            r_o_gain_cnt <= ev_gain ? r_gain_events + COUNT_W'(1) : r_gain_events;
            r_o_loss_cnt <= ev_loss ? r_loss_events + COUNT_W'(1) : r_loss_events;
            r_o_seen     <= r_seen;
        end
    end

    assign o_ratio            = r_o_ratio;
    assign o_gain_total       = r_o_gain;
    assign o_loss_total       = r_o_loss;
    assign o_gain_event       = r_o_gain_ev;
    assign o_loss_event       = r_o_loss_ev;
    assign o_gain_event_count = r_o_gain_cnt;
    assign o_loss_event_count = r_o_loss_cnt;
    assign o_sample_count     = r_o_seen;

endmodule

`default_nettype wire

/* rtl/rolling_gain_loss_ratio_core.sv */
// Rolling gain/loss ratio core: top level joining registers, sequencer and datapath.
//
// Input channel (i_in_valid / o_in_ready, i_sample): one signed Q16.16 sample per item.
// Output channel (o_out_valid / i_out_ready): one result item per input item, holding the
// ratio, the window sums, the event flags and the event and sample counters.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): always ready;
// a write to a listed register stores it and clears the window, sums and counters in the
// following cycle. Write only while no item is in flight.
// Divide path: an item whose ratio needs a divide goes through the remove, add, decide,
// divide, cap and publish steps after acceptance before it reaches the output register;
// the restoring divider retires one quotient bit a cycle over the full dividend. Items
// without a divide (fill below the threshold, no losses) skip the divide and cap steps.
// Intake: one item is worked on at a time; the next can be taken at the earliest in the
// cycle after the result is written.
// Reset (i_rst_n low at a clock edge) restores register defaults and empties the window,
// sums and counters. A stalled receiver holds the result in the output register; the
// block finishes the next item and waits in its publish step until the slot frees.
`default_nettype none

module rolling_gain_loss_ratio_core #(
    parameter int MAX_WINDOW    = rglr_pkg::MAX_WINDOW_DEF,
    parameter int FRACTION_BITS = rglr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [rglr_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [rglr_pkg::RATIO_W-1:0]                o_ratio,
    output logic [32+$clog2(MAX_WINDOW)-1:0]            o_gain_total,
    output logic [32+$clog2(MAX_WINDOW)-1:0]            o_loss_total,
    output logic                                        o_gain_event,
    output logic                                        o_loss_event,
    output logic [rglr_pkg::COUNT_W-1:0]                o_gain_event_count,
    output logic [rglr_pkg::COUNT_W-1:0]                o_loss_event_count,
    output logic [rglr_pkg::COUNT_W-1:0]                o_sample_count,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [rglr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [rglr_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DIV_W = 32 + $clog2(MAX_WINDOW) + FRACTION_BITS;

    rglr_pkg::t_cfg    cfg;
    rglr_pkg::t_cmd    cmd;
    rglr_pkg::t_status status;
    logic              clear;

    assign o_cfg_ready = 1'b1;

    rglr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clear     (clear)
    );

    rglr_ctrl #(
        .DIV_W (DIV_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rglr_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_clear            (clear),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_sample           (i_sample),
        .o_ratio            (o_ratio),
        .o_gain_total       (o_gain_total),
        .o_loss_total       (o_loss_total),
        .o_gain_event       (o_gain_event),
        .o_loss_event       (o_loss_event),
        .o_gain_event_count (o_gain_event_count),
        .o_loss_event_count (o_loss_event_count),
        .o_sample_count     (o_sample_count)
    );

endmodule

`default_nettype wire

/* rtl/rglr_checker.sv */
// Port-level checker of the gain/loss ratio core and its bind to the top level.
`default_nettype none
`include "rolling_gain_loss_ratio_core_assert.svh"

module rglr_checker #(
    parameter int MAX_WINDOW    = rglr_pkg::MAX_WINDOW_DEF,
    parameter int FRACTION_BITS = rglr_pkg::FRACTION_BITS_DEF
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_ready,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic                                i_cfg_valid,
    input wire logic [rglr_pkg::RATIO_W-1:0]        o_ratio,
    input wire logic [32+$clog2(MAX_WINDOW)-1:0]    o_gain_total,
    input wire logic [32+$clog2(MAX_WINDOW)-1:0]    o_loss_total,
    input wire logic [rglr_pkg::COUNT_W-1:0]        o_sample_count
);

    localparam logic [rglr_pkg::RATIO_W-1:0] RATIO_ONE = rglr_pkg::RATIO_W'(1) << FRACTION_BITS;

    `RGLR_ASSERT_AFTER_RESET(a_reset_idle, i_clk, i_rst_n, !o_out_valid && o_in_ready, "core not idle after reset")

    `RGLR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_cfg_valid, !o_in_ready, "core took an item while still busy")

    `RGLR_ASSERT_NOW(a_empty_window_ratio, i_clk, i_rst_n, o_out_valid && (o_gain_total == '0) && (o_loss_total == '0), o_ratio == RATIO_ONE, "ratio not 1.0 with empty sums")

    `RGLR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_ratio) && $stable(o_sample_count), "result changed while stalled")

endmodule

bind rolling_gain_loss_ratio_core rglr_checker #(
    .MAX_WINDOW    (MAX_WINDOW),
    .FRACTION_BITS (FRACTION_BITS)
) u_rglr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_cfg_valid    (i_cfg_valid),
    .o_ratio        (o_ratio),
    .o_gain_total   (o_gain_total),
    .o_loss_total   (o_loss_total),
    .o_sample_count (o_sample_count)
);

`default_nettype wire

/* dv/rolling_gain_loss_ratio_core_checker.sv */
// Checker of the gain/loss ratio core: shadows the window and compares every result item.
`timescale 1ns / 100ps

module rolling_gain_loss_ratio_core_checker
    import rglr_pkg::*;
#(
    parameter int SUM_W = MAG_W + $clog2(MAX_WINDOW_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [SAMPLE_W-1:0]         i_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [RATIO_W-1:0]          i_ratio,
    input  logic [SUM_W-1:0]            i_gain_total,
    input  logic [SUM_W-1:0]            i_loss_total,
    input  logic                        i_gain_event,
    input  logic                        i_loss_event,
    input  logic [COUNT_W-1:0]          i_gain_event_count,
    input  logic [COUNT_W-1:0]          i_loss_event_count,
    input  logic [COUNT_W-1:0]          i_sample_count,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output int                          o_mismatch_count,
    output int                          o_pending
);

    localparam int FRAC       = FRACTION_BITS_DEF;
    localparam int DEPTH      = MAX_WINDOW_DEF;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic [RATIO_W-1:0] ratio;
        logic [SUM_W-1:0]   gain_total;
        logic [SUM_W-1:0]   loss_total;
        logic               gain_event;
        logic               loss_event;
        logic [COUNT_W-1:0] gain_event_count;
        logic [COUNT_W-1:0] loss_event_count;
        logic [COUNT_W-1:0] sample_count;
    } t_ratio_result;

    // Shadow of the block's registers and window
    t_cfg                     cfg_now;
    logic signed [DELTA_W-1:0] delta_ring [DEPTH];
    logic [$clog2(DEPTH)-1:0] ring_head;
    logic [WIN_REG_W-1:0]     ring_fill;
    logic [SUM_W-1:0]         win_gain;
    logic [SUM_W-1:0]         win_loss;
    logic [SAMPLE_W-1:0]      prev_sample;
    logic                     have_prev;
    logic                     in_high_gain;
    logic                     in_high_loss;
    logic [COUNT_W-1:0]       gain_hits;
    logic [COUNT_W-1:0]       loss_hits;
    logic [COUNT_W-1:0]       samples_taken;

    t_ratio_result ratio_results_due [$];
    t_ratio_result due_item;
    int            fails = 0;
    int            items_checked = 0;

    task automatic clear_window();
        foreach (delta_ring[k]) delta_ring[k] = '0;
        ring_head     = '0;
        ring_fill     = '0;
        win_gain      = '0;
        win_loss      = '0;
        prev_sample   = '0;
        have_prev     = 1'b0;
        in_high_gain  = 1'b0;
        in_high_loss  = 1'b0;
        gain_hits     = '0;
        loss_hits     = '0;
        samples_taken = '0;
    endtask

    task automatic store_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_LENGTH:   cfg_now.window_length   = data[WIN_REG_W-1:0];
            REG_MIN_SAMPLES:     cfg_now.fill_need       = data[WIN_REG_W-1:0];
            REG_MAX_RATIO:       cfg_now.ratio_ceiling   = data[RATIO_W-1:0];
            REG_HIGH_GAIN_LEVEL: cfg_now.high_gain_level = data[RATIO_W-1:0];
            REG_HIGH_LOSS_LEVEL: cfg_now.high_loss_level = data[RATIO_W-1:0];
            default:             return;
        endcase
        clear_window();
    endtask

    // Take one sample into the window and work out the result item it yields
    task automatic advance_window(input logic [SAMPLE_W-1:0] smp, output t_ratio_result res);
        logic [WIN_REG_W-1:0]      win;
        logic [WIN_REG_W-1:0]      need;
        logic signed [DELTA_W-1:0] cur_ext;
        logic signed [DELTA_W-1:0] prev_ext;
        logic signed [DELTA_W-1:0] delta;
        logic signed [DELTA_W-1:0] old;
        logic [DELTA_W-1:0]        mag;
        logic [$clog2(DEPTH)-1:0]  slot;
        logic [63:0]               quot;
        logic [RATIO_W-1:0]        ratio;
        logic                      now_gain;
        logic                      now_loss;

        win = cfg_now.window_length;
        if (win < MIN_WINDOW) win = MIN_WINDOW;
        if (win > DEPTH) win = DEPTH;
        need = (cfg_now.fill_need < MIN_NEED) ? WIN_REG_W'(MIN_NEED) : cfg_now.fill_need;

        samples_taken = samples_taken + 1'b1;
        cur_ext  = {smp[SAMPLE_W-1], smp};
        prev_ext = {prev_sample[SAMPLE_W-1], prev_sample};
        delta    = have_prev ? (cur_ext - prev_ext) : '0;
        prev_sample = smp;
        have_prev   = 1'b1;

        // Drop the entry about to be overwritten from the sums
        slot = ring_head;
        if (slot >= win) slot = '0;
        old = delta_ring[slot];
        if (old > 0) begin
            win_gain = win_gain - {{(SUM_W-DELTA_W){1'b0}}, old};
        end else if (old < 0) begin
            mag = -old;
            win_loss = win_loss - {{(SUM_W-DELTA_W){1'b0}}, mag};
        end

        delta_ring[slot] = delta;
        ring_head = ({1'b0, slot} + 1'b1 >= win) ? '0 : slot + 1'b1;
        if (ring_fill < win) ring_fill = ring_fill + 1'b1;

        if (delta > 0) begin
            win_gain = win_gain + {{(SUM_W-DELTA_W){1'b0}}, delta};
        end else if (delta < 0) begin
            mag = -delta;
            win_loss = win_loss + {{(SUM_W-DELTA_W){1'b0}}, mag};
        end

        if (ring_fill >= need && win_loss != '0) begin
            quot  = (64'(win_gain) << FRAC) / 64'(win_loss);
            ratio = (quot > 64'(cfg_now.ratio_ceiling)) ?
                    cfg_now.ratio_ceiling : quot[RATIO_W-1:0];
        end else if (ring_fill >= need && win_gain != '0) begin
            ratio = cfg_now.ratio_ceiling;
        end else begin
            ratio = RATIO_W'(1) << FRAC;
        end

        now_gain = (ratio >= cfg_now.high_gain_level);
        now_loss = (ratio <= cfg_now.high_loss_level);
        res.gain_event = now_gain && !in_high_gain;
        res.loss_event = now_loss && !in_high_loss;
        if (res.gain_event) gain_hits = gain_hits + 1'b1;
        if (res.loss_event) loss_hits = loss_hits + 1'b1;
        in_high_gain = now_gain;
        in_high_loss = now_loss;

        res.ratio            = ratio;
        res.gain_total       = win_gain;
        res.loss_total       = win_loss;
        res.gain_event_count = gain_hits;
        res.loss_event_count = loss_hits;
        res.sample_count     = samples_taken;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= MAX_SHOWN)
                $display("result item %0d, %s: expected %0h, got %0h",
                         items_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_now.window_length   = WINDOW_LENGTH_RST;
            cfg_now.fill_need       = MIN_SAMPLES_RST;
            cfg_now.ratio_ceiling   = MAX_RATIO_RST;
            cfg_now.high_gain_level = HIGH_GAIN_LEVEL_RST;
            cfg_now.high_loss_level = HIGH_LOSS_LEVEL_RST;
            clear_window();
            ratio_results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (ratio_results_due.size() == 0) begin
                    fails++;
                    if (fails <= MAX_SHOWN)
                        $display("result item %0d arrived with none outstanding, ratio %0h",
                                 items_checked, i_ratio);
                end else begin
                    due_item = ratio_results_due.pop_front();
                    check_field("ratio", 64'(due_item.ratio), 64'(i_ratio));
                    check_field("gain_total", 64'(due_item.gain_total), 64'(i_gain_total));
                    check_field("loss_total", 64'(due_item.loss_total), 64'(i_loss_total));
                    check_field("gain_event", 64'(due_item.gain_event), 64'(i_gain_event));
                    check_field("loss_event", 64'(due_item.loss_event), 64'(i_loss_event));
                    check_field("gain_event_count", 64'(due_item.gain_event_count),
                                64'(i_gain_event_count));
                    check_field("loss_event_count", 64'(due_item.loss_event_count),
                                64'(i_loss_event_count));
                    check_field("sample_count", 64'(due_item.sample_count),
                                64'(i_sample_count));
                end
                items_checked++;
            end
            if (i_cfg_valid && i_cfg_ready)
                store_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                advance_window(i_sample, due_item);
                ratio_results_due.push_back(due_item);
            end
        end
        o_pending        <= ratio_results_due.size();
        o_mismatch_count <= fails;
    end

endmodule

/* dv/rolling_gain_loss_ratio_core_tb.sv */
// Testbench top of the gain/loss ratio core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module rolling_gain_loss_ratio_core_tb;
    import rglr_pkg::*;

    localparam int  SUM_W        = MAG_W + $clog2(MAX_WINDOW_DEF);
    localparam int  HALF_PERIOD  = 2;
    localparam int  RESET_CYCLES = 11;
    localparam int  SETTLE       = 64;
    localparam int  RANDOM_ITEMS = 500;
    localparam int  TIMEOUT_NS   = 2_000_000;
    localparam int  Q_ONE        = 1 << FRACTION_BITS_DEF;

    localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_HI = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [RATIO_W-1:0]    o_ratio;
    logic [SUM_W-1:0]      o_gain_total;
    logic [SUM_W-1:0]      o_loss_total;
    logic                  o_gain_event;
    logic                  o_loss_event;
    logic [COUNT_W-1:0]    o_gain_event_count;
    logic [COUNT_W-1:0]    o_loss_event_count;
    logic [COUNT_W-1:0]    o_sample_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_tally;
    int results_owed;
    int send_idle_pct = 0;
    int out_stall_pct = 0;

    always begin
        i_clk = 1'b0;
        #(HALF_PERIOD);
        i_clk = 1'b1;
        #(HALF_PERIOD);
    end

    rolling_gain_loss_ratio_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_sample           (i_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_ratio            (o_ratio),
        .o_gain_total       (o_gain_total),
        .o_loss_total       (o_loss_total),
        .o_gain_event       (o_gain_event),
        .o_loss_event       (o_loss_event),
        .o_gain_event_count (o_gain_event_count),
        .o_loss_event_count (o_loss_event_count),
        .o_sample_count     (o_sample_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    rolling_gain_loss_ratio_core_checker #(.SUM_W(SUM_W)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_sample           (i_sample),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_ratio            (o_ratio),
        .i_gain_total       (o_gain_total),
        .i_loss_total       (o_loss_total),
        .i_gain_event       (o_gain_event),
        .i_loss_event       (o_loss_event),
        .i_gain_event_count (o_gain_event_count),
        .i_loss_event_count (o_loss_event_count),
        .i_sample_count     (o_sample_count),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_mismatch_count   (fail_tally),
        .o_pending          (results_owed)
    );

    // Receiver: stall at random at the rate of the current phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin
                send_idle_pct = 0;
                out_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 59;
                out_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                out_stall_pct = 59;
            end
            default: begin
                send_idle_pct = 6;
                out_stall_pct = 6;
            end
        endcase
    endtask

    // Hold valid high across back-to-back items; drop it only for an idle gap
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Wait until every outstanding result item has been taken, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] prev,
                                                        input int up_pct,
                                                        input logic [31:0] span);
        int                  pick;
        logic [SAMPLE_W-1:0] step;
        pick = $urandom_range(99);
        step = $urandom_range(span);
        if (pick < 6) begin
            next_sample = $urandom;
        end else if (pick < 10) begin
            case ($urandom_range(3))
                0:       next_sample = 32'h7FFF_FFFF;
                1:       next_sample = 32'h8000_0000;
                2:       next_sample = '0;
                default: next_sample = prev;
            endcase
        end else if ($urandom_range(99) < up_pct) begin
            next_sample = prev + step;
        end else begin
            next_sample = prev - step;
        end
    endfunction

    initial begin : stimulus
        logic [SAMPLE_W-1:0] opening [9];
        logic [SAMPLE_W-1:0] prev;
        logic [31:0]         span;
        int                  up_pct;
        int                  phase;
        int                  burst;
        int                  random_sent;
        int                  pick;

        opening = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                    32'h0000_8000};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: full-range swings and a repeated sample
        set_idling(0);
        foreach (opening[k]) push_sample(opening[k]);
        // Unlisted index: must leave the window untouched
        write_reg(UNUSED_IDX_LO, 32'hFFFF_FFFF);
        set_idling(1);
        push_sample(32'h0002_0000);
        push_sample(32'h0000_0001);

        // Window below range, tiny fill threshold, widest ceiling and levels
        write_reg(REG_WINDOW_LENGTH, 32'd0);
        write_reg(REG_MIN_SAMPLES, 32'd1);
        write_reg(REG_MAX_RATIO, 32'hFFFF_FFFF);
        write_reg(REG_HIGH_GAIN_LEVEL, 32'd0);
        write_reg(REG_HIGH_LOSS_LEVEL, 32'hFFFF_FFFF);
        set_idling(2);
        for (int k = 1; k <= 5; k++) push_sample(32'(k));
        push_sample(32'h0000_0000);

        // Window above range, fill threshold never reached, zero ceiling
        write_reg(REG_WINDOW_LENGTH, 32'd127);
        write_reg(REG_MIN_SAMPLES, 32'd100);
        write_reg(REG_MAX_RATIO, 32'd0);
        write_reg(REG_HIGH_GAIN_LEVEL, 32'hFFFF_FFFF);
        write_reg(REG_HIGH_LOSS_LEVEL, 32'd0);
        write_reg(UNUSED_IDX_LO + 1'b1, 32'h0000_0000);
        write_reg(UNUSED_IDX_HI, 32'h5555_AAAA);
        set_idling(3);
        repeat (5) push_sample($urandom);

        // Saturate the ratio at a low ceiling
        write_reg(REG_WINDOW_LENGTH, 32'd4);
        write_reg(REG_MIN_SAMPLES, 32'd2);
        write_reg(REG_MAX_RATIO, 32'(3 * Q_ONE));
        write_reg(REG_HIGH_GAIN_LEVEL, 32'(HIGH_GAIN_LEVEL_RST));
        write_reg(REG_HIGH_LOSS_LEVEL, 32'(HIGH_LOSS_LEVEL_RST));
        set_idling(0);
        push_sample(32'h0000_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h7FFF_FFFE);

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(9);
            if (pick == 0)      write_reg(REG_WINDOW_LENGTH, $urandom_range(0, 3));
            else if (pick == 1) write_reg(REG_WINDOW_LENGTH, $urandom_range(65, 127));
            else if (pick == 2) write_reg(REG_WINDOW_LENGTH, MAX_WINDOW_DEF);
            else                write_reg(REG_WINDOW_LENGTH, $urandom_range(4, 24));

            pick = $urandom_range(9);
            if (pick == 0)      write_reg(REG_MIN_SAMPLES, $urandom_range(0, 1));
            else if (pick == 1) write_reg(REG_MIN_SAMPLES, $urandom_range(0, 127));
            else                write_reg(REG_MIN_SAMPLES, $urandom_range(2, 16));

            pick = $urandom_range(9);
            if (pick == 0)      write_reg(REG_MAX_RATIO, 32'd0);
            else if (pick == 1) write_reg(REG_MAX_RATIO, 32'hFFFF_FFFF);
            else if (pick == 2) write_reg(REG_MAX_RATIO, $urandom);
            else                write_reg(REG_MAX_RATIO, $urandom_range(Q_ONE, 200 * Q_ONE));

            pick = $urandom_range(9);
            if (pick == 0)      write_reg(REG_HIGH_GAIN_LEVEL, 32'd0);
            else if (pick == 1) write_reg(REG_HIGH_GAIN_LEVEL, 32'hFFFF_FFFF);
            else if (pick == 2) write_reg(REG_HIGH_GAIN_LEVEL, $urandom);
            else                write_reg(REG_HIGH_GAIN_LEVEL, $urandom_range(Q_ONE, 4 * Q_ONE));

            pick = $urandom_range(9);
            if (pick == 0)      write_reg(REG_HIGH_LOSS_LEVEL, 32'd0);
            else if (pick == 1) write_reg(REG_HIGH_LOSS_LEVEL, 32'hFFFF_FFFF);
            else if (pick == 2) write_reg(REG_HIGH_LOSS_LEVEL, $urandom);
            else                write_reg(REG_HIGH_LOSS_LEVEL, $urandom_range(0, Q_ONE));

            if ($urandom_range(3) == 0)
                write_reg(UNUSED_IDX_LO + CFG_IDX_W'($urandom_range(2)), $urandom);

            case ($urandom_range(3))
                0:       span = 32'd255;
                1:       span = 32'd65535;
                2:       span = 32'd1 << 20;
                default: span = 32'd1 << 27;
            endcase
            case ($urandom_range(2))
                0:       up_pct = 20;
                1:       up_pct = 50;
                default: up_pct = 80;
            endcase

            set_idling(phase);
            burst = $urandom_range(15, 60);
            prev = $urandom;
            // Shift the trend partway through so the ratio crosses the levels both ways
            for (int k = 0; k < burst; k++) begin
                if (k == burst / 2) up_pct = 100 - up_pct;
                prev = next_sample(prev, up_pct, span);
                push_sample(prev);
            end
            random_sent += burst;
            phase++;
        end

        drain();
        if (fail_tally == 0 && results_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* rolling_gain_loss_ratio_core.f */
+incdir+rtl
rtl/rglr_pkg.sv
rtl/rglr_regs.sv
rtl/rglr_ctrl.sv
rtl/rglr_datapath.sv
rtl/rolling_gain_loss_ratio_core.sv
rtl/rglr_checker.sv
dv/rolling_gain_loss_ratio_core_checker.sv
dv/rolling_gain_loss_ratio_core_tb.sv
